// File: hw/rtl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg: shared definitions for the binary arithmetic encoder
// Sequencer states, field widths and the control group that the
// renormalization unit returns to the sequencer.
// ----------------------------------------------------------------------------
package bae_pkg;

  // Default precision of the interval arithmetic.
  localparam int unsigned PRECISION_BITS_DEF = 16;

  // Fixed field widths of the streaming payloads.
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned CODE_W  = 17;
  localparam int unsigned COUNT_W = 5;

  // Item kinds carried on the input tuser.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CUT,
    ST_RENORM,
    ST_FIN
  } bae_state_t;

  // Decision of one renormalization step.
  typedef struct packed {
    logic stop;      // interval no longer lies in one half: no bit this step
    logic code_bit;  // bit emitted by this step when stop is low
  } bae_step_ctl_t;

endpackage

// File: hw/rtl/bae_renorm_unit.sv
// ----------------------------------------------------------------------------
// bae_renorm_unit: one interval doubling step
// Decides whether the interval lies in one half, gives the code bit, and
// produces the shifted interval. Shared by encode renormalization and flush.
// ----------------------------------------------------------------------------
module bae_renorm_unit #(
  parameter int unsigned PRECISION_BITS = bae_pkg::PRECISION_BITS_DEF
) (
  input  logic                             flush_i,
  input  logic signed [PRECISION_BITS+1:0] low_i,
  input  logic        [PRECISION_BITS+1:0] size_i,
  output bae_pkg::bae_step_ctl_t           ctl_o,
  output logic signed [PRECISION_BITS+1:0] low_o,
  output logic        [PRECISION_BITS+1:0] size_o
);

  localparam int unsigned W = PRECISION_BITS + 2;

  localparam logic signed [W:0]   ONE_X  = signed'((W+1)'(64'd1 << PRECISION_BITS));
  localparam logic signed [W:0]   HALF_X = signed'((W+1)'(64'd1 << (PRECISION_BITS - 1)));
  localparam logic signed [W-1:0] HALF_L = signed'(W'(64'd1 << (PRECISION_BITS - 1)));
  localparam logic        [W-1:0] ONE_U  = W'(64'd1 << PRECISION_BITS);
  localparam logic        [W-1:0] TWO_U  = W'(64'd1 << (PRECISION_BITS + 1));

  logic signed [W:0]   sum_x;
  logic                emit_zero;
  logic                emit_one;
  logic signed [W-1:0] low_sub;

  assign sum_x = $signed({low_i[W-1], low_i}) + $signed({1'b0, size_i});

  always_comb begin
    if (flush_i) begin
      emit_zero = (sum_x < ONE_X);
      emit_one  = (low_i > $signed(W'(0)));
    end else begin
      emit_zero = (sum_x <= HALF_X);
      emit_one  = (low_i >= HALF_L) && (sum_x <= ONE_X);
    end
  end

  assign ctl_o.stop     = !emit_zero && !emit_one;
  assign ctl_o.code_bit = !emit_zero;

  assign low_sub = emit_zero ? low_i : (low_i - HALF_L);
  assign low_o   = {low_sub[W-2:0], 1'b0};

  // During flush only "size at least one" matters once reached, so the size
  // saturates at twice the unit instead of growing without bound.
  always_comb begin
    if (flush_i && (size_i >= ONE_U)) begin
      size_o = TWO_U;
    end else begin
      size_o = {size_i[W-2:0], 1'b0};
    end
  end

endmodule

// File: hw/rtl/binary_arithmetic_encoder_core.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_core: binary arithmetic encoder
// Keeps a fixed-point interval, narrows it per encoded bit and emits code
// bits while renormalizing; a flush item emits the terminating bits.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: prob_zero, data_bit; tuser: op
//  out_    | master    | out_tvalid/tready  | tdata: code_bits, bit_count; tuser: fault
//
// Sequence: one transaction is worked on at a time. An encode item passes
// from acceptance through a multiply state, a state that cuts the interval,
// one doubling of the shared renormalization unit per emitted bit (at most
// PRECISION_BITS) plus the step that finds no more bits, and a final state
// that hands the result to the output register before in_tready rises
// again. A flush has no multiply and no cut; a faulting encode goes from
// the cut straight to the final state.
// Reset: synchronous and active low; the interval returns to offset zero
// and size two to the precision, and no result is pending.
// Stalls: the output register holds one finished result, so a new item is
// taken while that result waits; a second result waits in the final state
// until the output register frees.
//
module binary_arithmetic_encoder_core #(
  parameter int unsigned PRECISION_BITS = bae_pkg::PRECISION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] prob_zero, [16] data_bit, [23:17] zero
  input  logic        in_tuser,   // [0] op

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] code_bits, [21:17] bit_count, [23:22] zero
  output logic        out_tuser   // [0] fault
);

  localparam int unsigned W      = PRECISION_BITS + 2;          // interval register width
  localparam int unsigned PW     = PRECISION_BITS + 1 + bae_pkg::PROB_W; // product width
  localparam int unsigned CUT_W  = PRECISION_BITS + 1;          // cut bits kept after shift
  localparam int unsigned CMP_W  = (W > CUT_W) ? W : CUT_W;
  localparam logic [W-1:0] ONE_U = W'(64'd1 << PRECISION_BITS);

  bae_pkg::bae_state_t state_r, state_nxt;

  logic                         op_r, op_nxt;
  logic                         bit_r, bit_nxt;
  logic [bae_pkg::PROB_W-1:0]   prob_r, prob_nxt;
  logic [PW-1:0]                prod_r, prod_nxt;
  logic signed [W-1:0]          low_r, low_nxt;
  logic [W-1:0]                 size_r, size_nxt;
  logic [bae_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic [bae_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         fault_r, fault_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bae_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [bae_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                         out_fault_r, out_fault_nxt;

  logic                         in_accept;
  logic                         out_free;
  logic [CUT_W-1:0]             cut;
  logic                         cut_fault;

  bae_pkg::bae_step_ctl_t       step_ctl;
  logic signed [W-1:0]          step_low;
  logic [W-1:0]                 step_size;

  // Shared doubling unit, used once per cycle while renormalizing.
  bae_renorm_unit #(
    .PRECISION_BITS (PRECISION_BITS)
  ) u_renorm (
    .flush_i (op_r == bae_pkg::OP_FLUSH),
    .low_i   (low_r),
    .size_i  (size_r),
    .ctl_o   (step_ctl),
    .low_o   (step_low),
    .size_o  (step_size)
  );

  assign in_tready = (state_r == bae_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Cut of the interval: size times probability, scaled down by the precision.
  assign cut       = CUT_W'(prod_r >> PRECISION_BITS);
  assign cut_fault = (cut == '0) || (CMP_W'(cut) >= CMP_W'(size_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bae_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_tuser == bae_pkg::OP_FLUSH) ? bae_pkg::ST_RENORM
                                                      : bae_pkg::ST_MUL;
        end
      end
      bae_pkg::ST_MUL: begin
        state_nxt = bae_pkg::ST_CUT;
      end
      bae_pkg::ST_CUT: begin
        state_nxt = cut_fault ? bae_pkg::ST_FIN : bae_pkg::ST_RENORM;
      end
      bae_pkg::ST_RENORM: begin
        if (step_ctl.stop) begin
          state_nxt = bae_pkg::ST_FIN;
        end
      end
      bae_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = bae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bae_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and result register updates.
  always_comb begin
    op_nxt        = op_r;
    bit_nxt       = bit_r;
    prob_nxt      = prob_r;
    prod_nxt      = prod_r;
    low_nxt       = low_r;
    size_nxt      = size_r;
    code_nxt      = code_r;
    count_nxt     = count_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_code_nxt  = out_code_r;
    out_count_nxt = out_count_r;
    out_fault_nxt = out_fault_r;

    case (state_r)
      bae_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_tuser;
          prob_nxt  = in_tdata[15:0];
          bit_nxt   = in_tdata[16];
          code_nxt  = '0;
          count_nxt = '0;
          fault_nxt = 1'b0;
        end
      end
      bae_pkg::ST_MUL: begin
        prod_nxt = PW'(size_r[PRECISION_BITS:0]) * PW'(prob_r);
      end
      bae_pkg::ST_CUT: begin
        if (cut_fault) begin
          // Degenerate cut: report a fault and keep the interval.
          fault_nxt = 1'b1;
        end else if (bit_r) begin
          low_nxt  = low_r + $signed(W'(cut));
          size_nxt = size_r - W'(cut);
        end else begin
          size_nxt = W'(cut);
        end
      end
      bae_pkg::ST_RENORM: begin
        if (step_ctl.stop) begin
          // A flush restarts the coder once the terminating bits are out.
          if (op_r == bae_pkg::OP_FLUSH) begin
            low_nxt  = '0;
            size_nxt = ONE_U;
          end
        end else begin
          low_nxt   = step_low;
          size_nxt  = step_size;
          code_nxt  = {code_r[bae_pkg::CODE_W-2:0], step_ctl.code_bit};
          count_nxt = count_r + 1'b1;
        end
      end
      bae_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_count_nxt = count_r;
          out_fault_nxt = fault_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bae_pkg::ST_IDLE;
      low_r       <= '0;
      size_r      <= ONE_U;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    bit_r       <= bit_nxt;
    prob_r      <= prob_nxt;
    prod_r      <= prod_nxt;
    code_r      <= code_nxt;
    count_r     <= count_nxt;
    fault_r     <= fault_nxt;
    out_code_r  <= out_code_nxt;
    out_count_r <= out_count_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_code_r};
  assign out_tuser  = out_fault_r;

  // Checks on the sequencer and the interval.
  logic signed [W:0] idle_sum;
  assign idle_sum = $signed({low_r[W-1], low_r}) + $signed({1'b0, size_r});

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input ready right after an accepted transaction");

  // Between items the interval is nonempty and lies inside the unit range.
  a_idle_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::ST_IDLE) |->
      (low_r >= $signed(W'(0))) && (size_r != '0) &&
      (idle_sum <= $signed({1'b0, ONE_U})))
    else $error("interval out of range between transactions");

  // A faulting result carries no code bits.
  a_fault_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_count_r == '0) && (out_code_r == '0))
    else $error("fault result with emitted bits");

  // The final state only leaves when the output register can take the result.
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bae_pkg::ST_FIN) && out_free) |=> out_valid_r)
    else $error("finished result not loaded into output register");

endmodule
